[hdl/alid_pkg.sv]
// Shared types, codes and widths for the array list insert/delete unit.
`default_nettype none

package alid_pkg;

   // Default number of cells in the list.
   localparam int CAPACITY_DEF = 16;

   // Fixed field widths of the request and response beats.
   localparam int OP_W    = 3;
   localparam int DATA_W  = 32;
   localparam int POS_W   = 4;
   localparam int STAT_W  = 2;
   localparam int LEN_W   = 5;

   // Width wide enough to compare counts and positions at the largest capacity.
   localparam int LEN_MAX_W = 9;

   // Number of positions that a request can address.
   localparam int POS_N = 1 << POS_W;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
   localparam logic [OP_W-1:0] OP_READ   = 3'd4;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

   // Request beat.
   typedef struct packed {
      logic        [OP_W-1:0]   op;
      logic signed [DATA_W-1:0] value;
      logic        [POS_W-1:0]  position;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic        [STAT_W-1:0] status;
      logic        [LEN_W-1:0]  length;
      logic signed [DATA_W-1:0] read_value;
   } rsp_type;

   // Update that all cells apply in the same cycle.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_INSERT,
      CELL_DELETE,
      CELL_CLEAR
   } cell_op_type;

   // Command broadcast from the controller to the row of cells.
   typedef struct packed {
      cell_op_type                kind;
      logic [LEN_MAX_W-1:0]       pos;
      logic [LEN_MAX_W-1:0]       count;
      logic signed [DATA_W-1:0]   value;
   } cmd_type;

endpackage

`default_nettype wire

[hdl/alid_cell.sv]
// One list cell: holds one element and trades it with its neighbors.
`default_nettype none

module alid_cell #(
   parameter int INDEX = 0
) (
   input  wire                               clock,
   input  wire alid_pkg::cmd_type            cmd,
   input  wire logic signed [alid_pkg::DATA_W-1:0] left_data,
   input  wire logic signed [alid_pkg::DATA_W-1:0] right_data,
   output logic signed [alid_pkg::DATA_W-1:0]      data_ff
);

   localparam logic [alid_pkg::LEN_MAX_W-1:0] IDX = alid_pkg::LEN_MAX_W'(INDEX);

   logic signed [alid_pkg::DATA_W-1:0] data_in;

   // Pick the next element from self, neighbors, the new value or zero.
   always_comb begin
      data_in = data_ff;
      case (cmd.kind)
         alid_pkg::CELL_APPEND: begin
            if (IDX == cmd.count) data_in = cmd.value;
         end
         alid_pkg::CELL_INSERT: begin
            if (IDX > cmd.pos) data_in = left_data;
            else if (IDX == cmd.pos) data_in = cmd.value;
         end
         alid_pkg::CELL_DELETE: begin
            if (IDX >= cmd.pos) data_in = right_data;
         end
         alid_pkg::CELL_CLEAR: begin
            if (IDX < cmd.count) data_in = '0;
         end
         default: data_in = data_ff;
      endcase
   end

   // Hold the element.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

[hdl/alid_ctrl.sv]
// Request decode, length bookkeeping and response register.
`default_nettype none

module alid_ctrl #(
   parameter int CAPACITY = alid_pkg::CAPACITY_DEF
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_stall,
   input  wire alid_pkg::req_type                  req_payload,
   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output alid_pkg::rsp_type                       rsp_payload,
   input  wire logic signed [alid_pkg::DATA_W-1:0] rd_data,
   output alid_pkg::cmd_type                       cmd
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [alid_pkg::LEN_MAX_W-1:0] CAP_W = alid_pkg::LEN_MAX_W'(CAPACITY);

   logic [CNT_W-1:0]                   count_ff;
   logic [CNT_W-1:0]                   count_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   alid_pkg::rsp_type                  rsp_data_ff;
   alid_pkg::rsp_type                  rsp_data_in;
   logic                               accept;
   logic [alid_pkg::LEN_MAX_W-1:0]     count_w;
   logic [alid_pkg::LEN_MAX_W-1:0]     pos_w;
   logic [alid_pkg::STAT_W-1:0]        status;
   logic signed [alid_pkg::DATA_W-1:0] read_value;
   alid_pkg::cell_op_type              kind;

   // Take a beat whenever the response register is free or draining.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign count_w = alid_pkg::LEN_MAX_W'(count_ff);
   assign pos_w   = alid_pkg::LEN_MAX_W'(req_payload.position);

   // Check the request against the length and choose the cell update.
   always_comb begin
      status     = alid_pkg::ST_OK;
      kind       = alid_pkg::CELL_HOLD;
      count_in   = count_ff;
      read_value = '0;
      case (req_payload.op)
         alid_pkg::OP_APPEND: begin
            if (count_w >= CAP_W) begin
               status = alid_pkg::ST_FULL;
            end else begin
               kind     = alid_pkg::CELL_APPEND;
               count_in = count_ff + CNT_W'(1);
            end
         end
         alid_pkg::OP_INSERT: begin
            if (count_w == '0) begin
               status = alid_pkg::ST_EMPTY;
            end else if (count_w >= CAP_W) begin
               status = alid_pkg::ST_FULL;
            end else if (pos_w > count_w) begin
               status = alid_pkg::ST_RANGE;
            end else begin
               kind     = alid_pkg::CELL_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         alid_pkg::OP_DELETE: begin
            if (count_w == '0) begin
               status = alid_pkg::ST_EMPTY;
            end else if (pos_w >= count_w) begin
               status = alid_pkg::ST_RANGE;
            end else begin
               kind     = alid_pkg::CELL_DELETE;
               count_in = count_ff - CNT_W'(1);
            end
         end
         alid_pkg::OP_CLEAR: begin
            if (count_w == '0) begin
               status = alid_pkg::ST_EMPTY;
            end else begin
               kind = alid_pkg::CELL_CLEAR;
            end
         end
         alid_pkg::OP_READ: begin
            if (pos_w >= count_w) begin
               status = alid_pkg::ST_RANGE;
            end else begin
               read_value = rd_data;
            end
         end
         default: status = alid_pkg::ST_OK;
      endcase
      // Drop the update when no beat is taken.
      if (!accept) begin
         kind     = alid_pkg::CELL_HOLD;
         count_in = count_ff;
      end
   end

   assign cmd.kind  = kind;
   assign cmd.pos   = pos_w;
   assign cmd.count = count_w;
   assign cmd.value = req_payload.value;

   // Build the response beat from the updated length.
   always_comb begin
      rsp_data_in.status     = status;
      rsp_data_in.length     = alid_pkg::LEN_W'(count_in);
      rsp_data_in.read_value = read_value;
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   // Hold length and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the response payload on each accepted beat.
   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

[hdl/array_list_insert_delete_unit.sv]
// Top level of the array list insert/delete unit.
//
// Request channel (req_valid / req_stall / req_payload) carries one operation
// per beat: append, insert at position, delete at position, clear values or
// read. Response channel (rsp_valid / rsp_stall / rsp_payload) returns one
// beat per request with status, length after the operation and read value.
// The response is registered at the edge that takes the request. Throughput is
// one request per cycle while not stalled; the whole row of cells shifts in
// that same edge, each cell taking data from its left or right neighbor.
// When the receiver stalls, the response register holds its beat and
// req_stall rises, so no further request is taken until the beat drains.
// Reset (synchronous, active high) empties the list and drops rsp_valid;
// element values are not cleared and are only read once written.
// The reported length holds the low bits of the element count.
`default_nettype none

module array_list_insert_delete_unit #(
   parameter int CAPACITY = alid_pkg::CAPACITY_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire alid_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output alid_pkg::rsp_type      rsp_payload
);

   alid_pkg::cmd_type                  cmd;
   logic signed [alid_pkg::DATA_W-1:0] cell_data [CAPACITY];
   logic signed [alid_pkg::DATA_W-1:0] rd_tab [alid_pkg::POS_N];
   logic signed [alid_pkg::DATA_W-1:0] rd_data;

   alid_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .rd_data     (rd_data),
      .cmd         (cmd)
   );

   // Row of cells, each wired to its two neighbors.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [alid_pkg::DATA_W-1:0] left_data;
      logic signed [alid_pkg::DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = cmd.value;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      alid_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .data_ff    (cell_data[i])
      );
   end

   // Read port over the addressable cells; unbuilt positions read zero.
   for (genvar j = 0; j < alid_pkg::POS_N; j++) begin : g_rd
      if (j < CAPACITY) begin : g_cell_tap
         assign rd_tab[j] = cell_data[j];
      end else begin : g_zero
         assign rd_tab[j] = '0;
      end
   end

   assign rd_data = rd_tab[req_payload.position];

endmodule

`default_nettype wire

[hdl/alid_checker.sv]
// Port-level checks for the array list insert/delete unit, bound to the top.
`default_nettype none

module alid_checker #(
   parameter int CAPACITY = alid_pkg::CAPACITY_DEF
) (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_stall,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input wire alid_pkg::rsp_type rsp_payload
);

   // A stalled response beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response beat changed");

   // Every accepted request yields a response beat in the next cycle.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request gave no response");

   // A failed operation reads back zero.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != alid_pkg::ST_OK |->
         rsp_payload.read_value == '0)
      else $error("error response carries data");

   // An empty report comes with zero length.
   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == alid_pkg::ST_EMPTY |->
         rsp_payload.length == '0)
      else $error("empty status with nonzero length");

   // A full report comes with the length at capacity.
   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == alid_pkg::ST_FULL |->
         rsp_payload.length == alid_pkg::LEN_W'(CAPACITY))
      else $error("full status below capacity");

endmodule

bind array_list_insert_delete_unit alid_checker #(
   .CAPACITY (CAPACITY)
) u_alid_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
